/* rtl/xalu_pkg.sv */
// ----------------------------------------------------------------------------
// xalu_pkg
// Operation codes, width codes, stage payload types and width helpers shared
// by the x86-style ALU pipeline.
// ----------------------------------------------------------------------------
package xalu_pkg;

    localparam logic [3:0] F_ADD  = 4'd0;
    localparam logic [3:0] F_SUB  = 4'd1;
    localparam logic [3:0] F_CMP  = 4'd2;
    localparam logic [3:0] F_INC  = 4'd3;
    localparam logic [3:0] F_DEC  = 4'd4;
    localparam logic [3:0] F_NEG  = 4'd5;
    localparam logic [3:0] F_AND  = 4'd6;
    localparam logic [3:0] F_OR   = 4'd7;
    localparam logic [3:0] F_TEST = 4'd8;
    localparam logic [3:0] F_XOR  = 4'd9;
    localparam logic [3:0] F_NOT  = 4'd10;
    localparam logic [3:0] F_SHL  = 4'd11;
    localparam logic [3:0] F_SHR  = 4'd12;
    localparam logic [3:0] F_SAR  = 4'd13;
    localparam logic [3:0] F_ROL  = 4'd14;
    localparam logic [3:0] F_ROR  = 4'd15;

    localparam logic [1:0] SZ_8  = 2'd0;
    localparam logic [1:0] SZ_16 = 2'd1;

    typedef struct packed {
        logic        cf;
        logic        of;
        logic        zf;
        logic        sf;
        logic        pf;
    } t_flags;

    typedef struct packed {
        logic [3:0]  func;
        logic [1:0]  size;
        logic [31:0] d;
        logic [31:0] s;
        logic [31:0] add_a;
        logic [31:0] add_b;
        logic        add_cin;
        logic [4:0]  cnt;
        t_flags      flags;
    } t_s1;

    typedef struct packed {
        logic [1:0]  size;
        logic [31:0] r;
        logic        wb;
        logic        set_zsp;
        t_flags      flags;
    } t_s2;

    typedef struct packed {
        logic [31:0] r;
        logic        wb;
        t_flags      flags;
    } t_s3;

    function automatic logic [31:0] width_mask(input logic [1:0] size);
        logic [31:0] m;
        case (size)
            SZ_8:    m = 32'h0000_00FF;
            SZ_16:   m = 32'h0000_FFFF;
            default: m = 32'hFFFF_FFFF;
        endcase
        return m;
    endfunction

    function automatic logic [31:0] top_mask(input logic [1:0] size);
        logic [31:0] t;
        case (size)
            SZ_8:    t = 32'h0000_0080;
            SZ_16:   t = 32'h0000_8000;
            default: t = 32'h8000_0000;
        endcase
        return t;
    endfunction

endpackage

/* rtl/xalu_decode.sv */
// ----------------------------------------------------------------------------
// xalu_decode
// First stage: masks the operands to the operand width, prepares the adder
// operands and the shift or rotate count.
// ----------------------------------------------------------------------------
module xalu_decode (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  logic [3:0]    i_func,
    input  logic [1:0]    i_size,
    input  logic [31:0]   i_dest_value,
    input  logic [31:0]   i_src_value,
    input  xalu_pkg::t_flags i_flags,
    output logic          o_valid,
    output xalu_pkg::t_s1 o_data
);
    import xalu_pkg::*;

    logic        r_valid;
    t_s1         r_data;
    t_s1         n_data;
    logic [31:0] mask;

    always_comb begin
        mask           = width_mask(i_size);
        n_data.func    = i_func;
        n_data.size    = i_size;
        n_data.d       = i_dest_value & mask;
        n_data.s       = i_src_value & mask;
        n_data.flags   = i_flags;
        n_data.cnt     = i_src_value[4:0];
        if (i_func == F_ROL || i_func == F_ROR) begin
            case (i_size)
                SZ_8:    n_data.cnt = {2'b00, i_src_value[2:0]};
                SZ_16:   n_data.cnt = {1'b0, i_src_value[3:0]};
                default: n_data.cnt = i_src_value[4:0];
            endcase
        end
        n_data.add_a   = n_data.d;
        n_data.add_b   = n_data.s;
        n_data.add_cin = 1'b0;
        case (i_func) inside
            F_SUB, F_CMP: begin
                n_data.add_b   = ~n_data.s & mask;
                n_data.add_cin = 1'b1;
            end
            F_INC: begin
                n_data.add_b   = '0;
                n_data.add_cin = 1'b1;
            end
            F_DEC: begin
                n_data.add_b   = mask;
            end
            F_NEG: begin
                n_data.add_a   = '0;
                n_data.add_b   = ~n_data.d & mask;
                n_data.add_cin = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

/* rtl/xalu_exec.sv */
// ----------------------------------------------------------------------------
// xalu_exec
// Second stage: adder, logic unit, shifter and rotator, with the carry and
// overflow rules of the arithmetic and logic operations.
// ----------------------------------------------------------------------------
module xalu_exec (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  xalu_pkg::t_s1 i_data,
    output logic          o_valid,
    output xalu_pkg::t_s2 o_data
);
    import xalu_pkg::*;

    logic        r_valid;
    t_s2         r_data;
    t_s2         n_data;
    logic [31:0] mask;
    logic [31:0] top;
    logic [32:0] sum;
    logic [31:0] r_add;
    logic        carry;
    logic        of_ar;
    logic [31:0] ext;
    logic signed [31:0] sar_x;
    logic [31:0] sar_r;
    logic [15:0] rot8_l;
    logic [15:0] rot8_r;
    logic [31:0] rot16_l;
    logic [31:0] rot16_r;
    logic [63:0] rot32_l;
    logic [63:0] rot32_r;
    logic [31:0] rol_r;
    logic [31:0] ror_r;

    always_comb begin
        mask  = width_mask(i_data.size);
        top   = top_mask(i_data.size);
        sum   = {1'b0, i_data.add_a} + {1'b0, i_data.add_b} + {32'b0, i_data.add_cin};
        r_add = sum[31:0] & mask;
        case (i_data.size)
            SZ_8:    carry = sum[8];
            SZ_16:   carry = sum[16];
            default: carry = sum[32];
        endcase
        of_ar = |(~(i_data.add_a ^ i_data.add_b) & (i_data.add_a ^ r_add) & top);

        ext   = i_data.d | ((|(i_data.d & top)) ? ~mask : 32'h0);
        sar_x = $signed(ext) >>> i_data.cnt;
        sar_r = sar_x & mask;

        rot8_l  = {i_data.d[7:0], i_data.d[7:0]} << i_data.cnt[2:0];
        rot8_r  = {i_data.d[7:0], i_data.d[7:0]} >> i_data.cnt[2:0];
        rot16_l = {i_data.d[15:0], i_data.d[15:0]} << i_data.cnt[3:0];
        rot16_r = {i_data.d[15:0], i_data.d[15:0]} >> i_data.cnt[3:0];
        rot32_l = {i_data.d, i_data.d} << i_data.cnt;
        rot32_r = {i_data.d, i_data.d} >> i_data.cnt;
        case (i_data.size)
            SZ_8: begin
                rol_r = {24'h0, rot8_l[15:8]};
                ror_r = {24'h0, rot8_r[7:0]};
            end
            SZ_16: begin
                rol_r = {16'h0, rot16_l[31:16]};
                ror_r = {16'h0, rot16_r[15:0]};
            end
            default: begin
                rol_r = rot32_l[63:32];
                ror_r = rot32_r[31:0];
            end
        endcase

        n_data.size    = i_data.size;
        n_data.flags   = i_data.flags;
        n_data.wb      = 1'b1;
        n_data.set_zsp = 1'b1;
        n_data.r       = r_add;
        case (i_data.func) inside
            F_ADD: begin
                n_data.flags.cf = carry;
                n_data.flags.of = of_ar;
            end
            F_SUB, F_CMP: begin
                n_data.flags.cf = ~carry;
                n_data.flags.of = of_ar;
                n_data.wb       = (i_data.func != F_CMP);
            end
            F_INC, F_DEC: begin
                n_data.flags.of = of_ar;
            end
            F_NEG: begin
                n_data.flags.cf = |i_data.d;
                n_data.flags.of = of_ar;
            end
            F_AND, F_TEST: begin
                n_data.r        = i_data.d & i_data.s;
                n_data.flags.cf = 1'b0;
                n_data.flags.of = 1'b0;
                n_data.wb       = (i_data.func != F_TEST);
            end
            F_OR: begin
                n_data.r        = i_data.d | i_data.s;
                n_data.flags.cf = 1'b0;
                n_data.flags.of = 1'b0;
            end
            F_XOR: begin
                n_data.r        = i_data.d ^ i_data.s;
                n_data.flags.cf = 1'b0;
                n_data.flags.of = 1'b0;
            end
            F_NOT: begin
                n_data.r       = ~i_data.d & mask;
                n_data.set_zsp = 1'b0;
            end
            F_SHL:   n_data.r = (i_data.d << i_data.cnt) & mask;
            F_SHR:   n_data.r = i_data.d >> i_data.cnt;
            F_SAR:   n_data.r = sar_r;
            F_ROL:   n_data.r = rol_r;
            default: n_data.r = ror_r;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

/* rtl/xalu_flags.sv */
// ----------------------------------------------------------------------------
// xalu_flags
// Third stage: zero, sign and parity flags from the result (NOT keeps the
// input ones), held in the output register.
// ----------------------------------------------------------------------------
module xalu_flags (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  xalu_pkg::t_s2 i_data,
    output logic          o_valid,
    output xalu_pkg::t_s3 o_data
);
    import xalu_pkg::*;

    logic r_valid;
    t_s3  r_data;
    t_s3  n_data;

    always_comb begin
        n_data.r     = i_data.r;
        n_data.wb    = i_data.wb;
        n_data.flags = i_data.flags;
        if (i_data.set_zsp) begin
            n_data.flags.zf = (i_data.r == 32'h0);
            n_data.flags.sf = |(i_data.r & top_mask(i_data.size));
            n_data.flags.pf = ~^i_data.r[7:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

/* rtl/x86_alu_with_flags.sv */
// ----------------------------------------------------------------------------
// x86_alu_with_flags
// Three-stage pipelined x86-style integer ALU with status flags.
// ----------------------------------------------------------------------------
// A request carries an operation, an operand width, two operands and the
// current flags on the input channel (i_valid, o_stall); it is taken at a
// clock edge where i_valid is high and o_stall is low. The result, the
// write-back mark and the new flags leave on the output channel (o_valid,
// i_stall) and are taken at an edge where o_valid is high and i_stall low.
// The pipeline has three register stages: operand preparation, the adder
// and shifter, and the flag stage that also holds the output register.
// A new request can be taken every cycle while o_stall is low. While the
// receiver stalls, the output holds steady and the stages behind it keep
// filling until all three are occupied; only then is o_stall raised. Reset
// empties every stage.
// ----------------------------------------------------------------------------
module x86_alu_with_flags (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [3:0]  i_func,
    input  logic [1:0]  i_size,
    input  logic [31:0] i_dest_value,
    input  logic [31:0] i_src_value,
    input  logic        i_carry_in,
    input  logic        i_overflow_in,
    input  logic        i_zero_in,
    input  logic        i_sign_in,
    input  logic        i_parity_in,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_result,
    output logic        o_write_back,
    output logic        o_carry_out,
    output logic        o_overflow_out,
    output logic        o_zero_out,
    output logic        o_sign_out,
    output logic        o_parity_out
);
    import xalu_pkg::*;

    t_flags flags_in;
    logic   v1;
    logic   v2;
    logic   v3;
    logic   en1;
    logic   en2;
    logic   en3;
    t_s1    s1;
    t_s2    s2;
    t_s3    s3;

    assign flags_in = '{cf: i_carry_in, of: i_overflow_in, zf: i_zero_in,
                        sf: i_sign_in, pf: i_parity_in};

    assign en3     = ~v3 | ~i_stall;
    assign en2     = ~v2 | en3;
    assign en1     = ~v1 | en2;
    assign o_stall = ~en1;

    xalu_decode u_decode (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (en1),
        .i_valid      (i_valid),
        .i_func       (i_func),
        .i_size       (i_size),
        .i_dest_value (i_dest_value),
        .i_src_value  (i_src_value),
        .i_flags      (flags_in),
        .o_valid      (v1),
        .o_data       (s1)
    );

    xalu_exec u_exec (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en2),
        .i_valid (v1),
        .i_data  (s1),
        .o_valid (v2),
        .o_data  (s2)
    );

    xalu_flags u_flags (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en3),
        .i_valid (v2),
        .i_data  (s2),
        .o_valid (v3),
        .o_data  (s3)
    );

    assign o_valid        = v3;
    assign o_result       = s3.r;
    assign o_write_back   = s3.wb;
    assign o_carry_out    = s3.flags.cf;
    assign o_overflow_out = s3.flags.of;
    assign o_zero_out     = s3.flags.zf;
    assign o_sign_out     = s3.flags.sf;
    assign o_parity_out   = s3.flags.pf;

endmodule

/* rtl/xalu_checker.sv */
// ----------------------------------------------------------------------------
// xalu_checker
// Port-level checks of the ALU pipeline: reset, back-pressure and latency.
// ----------------------------------------------------------------------------
module xalu_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic        o_stall,
    input  logic        o_valid,
    input  logic        i_stall,
    input  logic [31:0] o_result
);

    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("Output valid after reset.");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_result))
        else $error("Stalled output changed.");

    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("Input stalled although the output was not blocked.");

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall ##1 !i_stall ##1 !i_stall |=> o_valid)
        else $error("Request did not reach the output in three cycles.");

endmodule

bind x86_alu_with_flags xalu_checker u_xalu_checker (.*);
